// ----- src/hbtf_pkg.sv -----
// Shared types, constants and the cell transition table for the half-block
// text framebuffer. No dependencies.
package hbtf_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int ROW_PIXELS = 16;

   localparam int CELL_COUNT = MAX_WIDTH * (MAX_HEIGHT / 2);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT / 2);
   localparam int STEP_W     = $clog2(ROW_PIXELS);
   localparam int COUNT_W    = $clog2(ROW_PIXELS + 1);

   localparam int REG_W   = 7;
   localparam int POS_W   = 8;
   localparam int CODE_W  = 8;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 7'd48;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 7'd48;
   localparam logic [REG_W-1:0] WIDTH_MAX    = REG_W'(MAX_WIDTH);
   localparam logic [REG_W-1:0] HEIGHT_MAX   = REG_W'(MAX_HEIGHT);

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [CODE_W-1:0] CODE_EMPTY = 8'h20;
   localparam logic [CODE_W-1:0] CODE_SOLID = 8'hdb;
   localparam logic [CODE_W-1:0] CODE_LOWER = 8'hdc;
   localparam logic [CODE_W-1:0] CODE_UPPER = 8'hdf;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SET   = 2'd1,
      CMD_ROW   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CLEAR  = 6'b000010,
      ST_BASE   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_MODIFY = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // index: lower-row flag, new value, class of the old code
   localparam logic [CODE_W-1:0] NEXT_CODE_TABLE [16] = '{
      CODE_EMPTY, CODE_LOWER, CODE_EMPTY, CODE_LOWER,
      CODE_UPPER, CODE_SOLID, CODE_UPPER, CODE_SOLID,
      CODE_EMPTY, CODE_EMPTY, CODE_UPPER, CODE_UPPER,
      CODE_LOWER, CODE_LOWER, CODE_SOLID, CODE_SOLID
   };

   function automatic logic [CODE_W-1:0] next_code(input logic lower_row,
                                                   input logic value,
                                                   input logic [CODE_W-1:0] old);
      logic [1:0] cls;
      if (old == CODE_EMPTY) begin
         cls = 2'd0;
      end else if (old == CODE_LOWER) begin
         cls = 2'd1;
      end else if (old == CODE_UPPER) begin
         cls = 2'd2;
      end else begin
         cls = 2'd3;   // solid and any unknown code
      end
      return NEXT_CODE_TABLE[{lower_row, value, cls}];
   endfunction

endpackage

// ----- src/half_block_text_framebuffer_top.sv -----
// Half-block text framebuffer, one request at a time. Clear writes every cell in turn.
//   set pixel / read cell: base, read, modify, done; off screen, read goes to done.
//   draw row: read per pixel, modify per drawn one (read then write of one cell port).
// The input is free again from the cycle the response is presented, even while it waits.
// Synchronous reset: sequencer idle, walk counter zero, size registers 48 x 48,
// cell store contents undefined until the first clear. Depends on hbtf_pkg.
module half_block_text_framebuffer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [hbtf_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [hbtf_pkg::POS_W-1:0] req_pos_y,
   input  logic                          req_pixel_on,
   input  logic [hbtf_pkg::ROW_PIXELS-1:0] req_row_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hbtf_pkg::CODE_W-1:0]   rsp_cell_code,
   output logic [hbtf_pkg::COUNT_W-1:0]  rsp_pixels_written,
   output logic                          rsp_in_range,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [hbtf_pkg::REG_W-1:0]    csr_wdata
);
   import hbtf_pkg::*;

   // registers and their next values
   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [POS_W-1:0]        x_ff, x_in;
   logic [POS_W-1:0]        y_ff, y_in;
   logic                    on_ff, on_in;
   logic [ROW_PIXELS-1:0]   bits_ff, bits_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       walk_ff, walk_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    inside_ff, inside_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_inside_ff, rsp_inside_in;
   logic [REG_W-1:0]        width_ff, width_in;
   logic [REG_W-1:0]        height_ff, height_in;

   // cell store
   logic [CODE_W-1:0]       cell_mem [CELL_COUNT];
   logic [CODE_W-1:0]       rdata_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_addr;
   logic [CODE_W-1:0]       mem_wdata;

   // effective screen size
   logic [REG_W-1:0]        width_eff;
   logic [REG_W-1:0]        pix_rows_eff;
   logic [REG_W-1:0]        char_rows_eff;
   logic [REG_W-1:0]        height_sat;

   logic [ROW_W-1:0]        base_row;
   logic [ROW_W+REG_W-1:0]  base_prod;
   logic [POS_W:0]          col;
   logic                    pix_inside, read_inside;
   logic                    last_step;
   logic                    req_accept, rsp_free;

   always_comb begin
      if (width_ff == '0) begin
         width_eff = REG_W'(1);
      end else if (width_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < REG_W'(2)) begin
         height_sat = REG_W'(2);
      end else if (height_ff > HEIGHT_MAX) begin
         height_sat = HEIGHT_MAX;
      end else begin
         height_sat = height_ff;
      end
      // odd last pixel row has no full cell
      pix_rows_eff  = {height_sat[REG_W-1:1], 1'b0};
      char_rows_eff = {1'b0, height_sat[REG_W-1:1]};
   end

   // column of the current pixel of the run, signed, one bit wider than pos_x
   assign col = {x_ff[POS_W-1], x_ff} + {{(POS_W+1-STEP_W){1'b0}}, step_ff};

   assign pix_inside = !col[POS_W] && ({1'b0, col[POS_W-1:0]} < {2'b00, width_eff})
                    && !y_ff[POS_W-1] && (y_ff[POS_W-2:0] < pix_rows_eff);
   assign read_inside = !x_ff[POS_W-1] && (x_ff[POS_W-2:0] < width_eff)
                     && !y_ff[POS_W-1] && (y_ff[POS_W-2:0] < char_rows_eff);

   assign base_row  = (cmd_ff == CMD_READ) ? y_ff[ROW_W-1:0] : y_ff[ROW_W:1];
   assign base_prod = {{REG_W{1'b0}}, base_row} * {{ROW_W{1'b0}}, width_eff};

   assign last_step  = (cmd_ff == CMD_SET) || (step_ff == STEP_W'(ROW_PIXELS - 1));
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      on_in         = on_ff;
      bits_in       = bits_ff;
      step_in       = step_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      walk_in       = walk_ff;
      count_in      = count_ff;
      inside_in     = inside_ff;
      code_in       = code_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = addr_ff;
      mem_wdata     = CODE_EMPTY;

      if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = cmd_type'(req_command);
               x_in      = req_pos_x;
               y_in      = req_pos_y;
               on_in     = req_pixel_on;
               bits_in   = req_row_bits;
               step_in   = '0;
               count_in  = '0;
               inside_in = 1'b0;
               code_in   = '0;
               state_in  = (cmd_type'(req_command) == CMD_CLEAR) ? ST_CLEAR : ST_BASE;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = walk_ff;
            mem_wdata = CODE_EMPTY;
            walk_in   = walk_ff + ADDR_W'(1);   // wraps back to zero on the last cell
            if (walk_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_BASE: begin
            base_in  = base_prod[ADDR_W-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            if (cmd_ff == CMD_READ) begin
               if (read_inside) begin
                  mem_re    = 1'b1;
                  mem_addr  = base_ff + ADDR_W'(x_ff[COL_W-1:0]);
                  inside_in = 1'b1;
                  state_in  = ST_MODIFY;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (pix_inside) begin
               mem_re   = 1'b1;
               mem_addr = base_ff + ADDR_W'(col[COL_W-1:0]);
               addr_in  = mem_addr;
               state_in = ST_MODIFY;
            end else if (last_step) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
               bits_in = {bits_ff[ROW_PIXELS-2:0], 1'b0};
            end
         end
         ST_MODIFY: begin
            if (cmd_ff == CMD_READ) begin
               code_in  = rdata_ff;
               state_in = ST_DONE;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = addr_ff;
               // set pixel takes pixel_on, a run takes the leading bit
               mem_wdata = next_code(y_ff[0],
                                     (cmd_ff == CMD_SET) ? on_ff : bits_ff[ROW_PIXELS-1],
                                     rdata_ff);
               count_in  = count_ff + COUNT_W'(1);
               inside_in = 1'b1;
               if (last_step) begin
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  bits_in  = {bits_ff[ROW_PIXELS-2:0], 1'b0};
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = code_ff;
               rsp_count_in  = count_ff;
               rsp_inside_in = inside_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      on_ff         <= on_in;
      bits_ff       <= bits_in;
      step_ff       <= step_in;
      base_ff       <= base_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      inside_ff     <= inside_in;
      code_ff       <= code_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= cell_mem[mem_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_code      = rsp_code_ff;
   assign rsp_pixels_written = rsp_count_ff;
   assign rsp_in_range       = rsp_inside_ff;

endmodule

// ----- src/hbtf_checker.sv -----
// Port-level checks for the half-block text framebuffer, bound to the top level.
// Depends on hbtf_pkg and half_block_text_framebuffer_top.
module hbtf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [hbtf_pkg::CODE_W-1:0]   rsp_cell_code,
   input logic [hbtf_pkg::COUNT_W-1:0]  rsp_pixels_written,
   input logic                          rsp_in_range
);
   import hbtf_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_code)
         && $stable(rsp_pixels_written) && $stable(rsp_in_range))
      else $error("stalled response changed");

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting a request");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_code != '0 |-> rsp_in_range)
      else $error("cell code returned for an address off screen");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixels_written != '0 |-> rsp_in_range
         && rsp_pixels_written <= COUNT_W'(ROW_PIXELS))
      else $error("pixel count inconsistent");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind half_block_text_framebuffer_top hbtf_checker u_hbtf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_cell_code      (rsp_cell_code),
   .rsp_pixels_written (rsp_pixels_written),
   .rsp_in_range       (rsp_in_range)
);
